>>> rtl/frlim_pkg.sv
// Shared types and constants for the flash ring log index manager.
// No dependencies; every other file in rtl/ imports this package.
package frlim_pkg;

  // Ring and flash geometry (record and page sizes are powers of two)
  localparam int RECORD_BYTES = 32;
  localparam int PAGE_BYTES   = 512;
  localparam int SLOT_COUNT   = 4096;
  localparam int FIRST_SLOT   = 0;

  // Field widths
  localparam int OP_W   = 3;
  localparam int SLOT_W = 12;
  localparam int PAGE_W = 8;
  localparam int OFF_W  = 9;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 3'd0,
    OP_GET    = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_SET_RD = 3'd3,
    OP_SET_WR = 3'd4
  } op_e;

  // Flash access kinds
  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_WRITE = 2'd1,
    ACC_READ  = 2'd2
  } acc_e;

  // Result status
  typedef enum logic {
    STAT_OK    = 1'b0,
    STAT_EMPTY = 1'b1
  } stat_e;

  // One operation request
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] new_index;
  } item_t;

  // One operation result
  typedef struct packed {
    stat_e             status;
    logic              erase;
    acc_e              access;
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  offset;
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] unread;
  } result_t;

endpackage

>>> rtl/flash_ring_log_index_manager_top.sv
// Flash ring log index manager: read/write slot pointers for a record ring in paged flash.
// Path from input transfer to result transfer: input register, then result register.
// Throughput: one operation per cycle while the result side does not stall; the pointer update is combinational.
// Reset: asynchronous, active low; clears both pointers to the first slot and empties
// both registers. Depends on frlim_pkg, frlim_in_stage, frlim_core, frlim_out_stage.
module flash_ring_log_index_manager_top
  import frlim_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [SLOT_W-1:0] new_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              status_o,
  output logic              erase_page_now_o,
  output logic [1:0]        flash_access_o,
  output logic [PAGE_W-1:0] flash_page_o,
  output logic [OFF_W-1:0]  page_offset_o,
  output logic [SLOT_W-1:0] read_slot_now_o,
  output logic [SLOT_W-1:0] write_slot_now_o,
  output logic [SLOT_W-1:0] unread_count_o
);

  item_t   in_item, held_item;
  logic    held_valid, out_free, adv;
  result_t core_res, out_res;

  assign in_item.op        = op_i;
  assign in_item.new_index = new_index_i;

  // A held request moves into the result register when that has room
  assign adv = held_valid && out_free;

  frlim_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  frlim_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (held_item),
    .result_o (core_res)
  );

  frlim_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .result_i    (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign status_o         = out_res.status;
  assign erase_page_now_o = out_res.erase;
  assign flash_access_o   = out_res.access;
  assign flash_page_o     = out_res.page;
  assign page_offset_o    = out_res.offset;
  assign read_slot_now_o  = out_res.rd_slot;
  assign write_slot_now_o = out_res.wr_slot;
  assign unread_count_o   = out_res.unread;

  // An empty get never issues a flash access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_EMPTY |-> flash_access_o == ACC_NONE)
    else $error("empty get issued a flash access");

  // Erase only comes with a write at a page start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && erase_page_now_o |-> flash_access_o == ACC_WRITE && page_offset_o == '0)
    else $error("erase without page-aligned write");

  // Equal pointers and a zero count go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_slot_now_o == write_slot_now_o) == (unread_count_o == '0))
    else $error("unread count disagrees with pointers");

  // A stalled input means a request is held and the result side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> held_valid && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

>>> rtl/frlim_in_stage.sv
// Input register of the index manager: captures one request per transfer.
// Depends on frlim_pkg (item_t).
module frlim_in_stage
  import frlim_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  adv_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;
  logic  take;

  // Free when empty or when the held request moves on this cycle
  assign in_stall_o = valid_q && !adv_i;
  assign take       = in_valid_i && !in_stall_o;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/frlim_core.sv
// Pointer state and per-operation logic: flash command, page split and pointer update.
// Depends on frlim_pkg (geometry constants, op/access/status codes, structs).
module frlim_core
  import frlim_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam int REC_SHIFT  = $clog2(RECORD_BYTES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = SLOT_W + REC_SHIFT;
  localparam int NB_W       = ADDR_W + 1;
  localparam int CNT_W      = SLOT_W + 1;
  localparam logic [CNT_W-1:0]  SLOT_END = CNT_W'(SLOT_COUNT);
  localparam logic [SLOT_W-1:0] FIRST    = SLOT_W'(FIRST_SLOT);

  logic [SLOT_W-1:0] wr_q, wr_d;
  logic [SLOT_W-1:0] rd_q, rd_d;

  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic [ADDR_W-1:0]     wr_page, rd_page;
  logic [PAGE_SHIFT-1:0] wr_off, rd_off;
  logic [NB_W-1:0]       next_pg_byte, jump_raw;
  logic [SLOT_W-1:0]     jump_slot, wr_inc, rd_inc, idx_wrap;
  logic [CNT_W-1:0]      wr_sum, rd_sum;
  logic [SLOT_W-1:0]     cur_unread;
  result_t               res;

  // Records between the pointers; equal pointers mean empty
  function automatic logic [SLOT_W-1:0] ring_fill(input logic [SLOT_W-1:0] w,
                                                  input logic [SLOT_W-1:0] r);
    logic [CNT_W-1:0] wrap_sum;
    wrap_sum = CNT_W'(w) + SLOT_END - CNT_W'(r) - CNT_W'(FIRST);
    if (w > r) begin
      return w - r;
    end else if (r > w) begin
      return wrap_sum[SLOT_W-1:0];
    end else begin
      return '0;
    end
  endfunction

  // Byte address split into page and offset
  assign wr_addr = ADDR_W'(wr_q) << REC_SHIFT;
  assign rd_addr = ADDR_W'(rd_q) << REC_SHIFT;
  assign wr_page = wr_addr >> PAGE_SHIFT;
  assign rd_page = rd_addr >> PAGE_SHIFT;
  assign wr_off  = wr_addr[PAGE_SHIFT-1:0];
  assign rd_off  = rd_addr[PAGE_SHIFT-1:0];

  // First slot whose record starts on the page after the writer's
  assign next_pg_byte = (NB_W'(wr_page) + NB_W'(1)) << PAGE_SHIFT;
  assign jump_raw     = (next_pg_byte + NB_W'(RECORD_BYTES - 1)) >> REC_SHIFT;
  assign jump_slot    = (jump_raw >= NB_W'(SLOT_COUNT)) ? FIRST : jump_raw[SLOT_W-1:0];

  // Pointer increments with wrap
  assign wr_sum   = CNT_W'(wr_q) + CNT_W'(1);
  assign rd_sum   = CNT_W'(rd_q) + CNT_W'(1);
  assign wr_inc   = (wr_sum >= SLOT_END) ? FIRST : wr_sum[SLOT_W-1:0];
  assign rd_inc   = (rd_sum >= SLOT_END) ? FIRST : rd_sum[SLOT_W-1:0];
  assign idx_wrap = (CNT_W'(item_i.new_index) >= SLOT_END) ? FIRST : item_i.new_index;

  assign cur_unread = ring_fill(wr_q, rd_q);

  // Operation decode
  always_comb begin
    wr_d        = wr_q;
    rd_d        = rd_q;
    res         = '0;
    res.status  = STAT_OK;
    res.access  = ACC_NONE;
    unique case (op_e'(item_i.op))
      OP_PUT: begin
        res.access = ACC_WRITE;
        res.page   = PAGE_W'(wr_page);
        res.offset = OFF_W'(wr_off);
        if (wr_off == '0) begin
          res.erase = 1'b1;
          // unread records on the page being erased are dropped
          if (wr_q < rd_q && wr_page == rd_page) begin
            rd_d = jump_slot;
          end
        end
        wr_d = wr_inc;
      end
      OP_GET: begin
        if (cur_unread == '0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.access = ACC_READ;
          res.page   = PAGE_W'(rd_page);
          res.offset = OFF_W'(rd_off);
          rd_d       = rd_inc;
        end
      end
      OP_CLEAR: begin
        wr_d = FIRST;
        rd_d = FIRST;
      end
      OP_SET_RD: rd_d = idx_wrap;
      OP_SET_WR: wr_d = idx_wrap;
      default: ;
    endcase
    res.rd_slot = rd_d;
    res.wr_slot = wr_d;
    res.unread  = ring_fill(wr_d, rd_d);
  end

  // Pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= FIRST;
      rd_q <= FIRST;
    end else if (adv_i) begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  assign result_o = res;

endmodule

>>> rtl/frlim_out_stage.sv
// Result register of the index manager: holds one result until its transfer.
// Depends on frlim_pkg (result_t).
module frlim_out_stage
  import frlim_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  // Can load when empty or when the held result is taken this cycle
  assign free_o = !valid_q || !out_stall_i;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

>>> verif/tb_flash_ring_log_index_manager_top.sv
// Self-checking testbench for flash_ring_log_index_manager_top: directed and random ring ops,
// checked against a built-in predictor of the slot pointers. Depends on frlim_pkg and the RTL.
`timescale 1ns / 100ps

module tb_flash_ring_log_index_manager_top;
  import frlim_pkg::*;

  localparam int ITEMS_PER_PHASE = 440;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int SLOTS_PER_PAGE  = PAGE_BYTES / RECORD_BYTES;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   op_i           = OP_PUT;
  logic [SLOT_W-1:0] new_index_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic              status_o;
  logic              erase_page_now_o;
  logic [1:0]        flash_access_o;
  logic [PAGE_W-1:0] flash_page_o;
  logic [OFF_W-1:0]  page_offset_o;
  logic [SLOT_W-1:0] read_slot_now_o;
  logic [SLOT_W-1:0] write_slot_now_o;
  logic [SLOT_W-1:0] unread_count_o;

  flash_ring_log_index_manager_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .new_index_i      (new_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .erase_page_now_o (erase_page_now_o),
    .flash_access_o   (flash_access_o),
    .flash_page_o     (flash_page_o),
    .page_offset_o    (page_offset_o),
    .read_slot_now_o  (read_slot_now_o),
    .write_slot_now_o (write_slot_now_o),
    .unread_count_o   (unread_count_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  item_t       op_queue[$];
  result_t     expected_results[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          stall_pct      = 0;
  int          quiet_cycles   = 0;

  // predictor state
  logic [SLOT_W-1:0] rd_ptr = SLOT_W'(FIRST_SLOT);
  logic [SLOT_W-1:0] wr_ptr = SLOT_W'(FIRST_SLOT);

  function automatic int unsigned ring_slot(int unsigned s);
    if (s < FIRST_SLOT || s >= SLOT_COUNT) return FIRST_SLOT;
    return s;
  endfunction

  function automatic int unsigned slot_page(int unsigned s);
    return (s * RECORD_BYTES) / PAGE_BYTES;
  endfunction

  function automatic int unsigned slot_offset(int unsigned s);
    return (s * RECORD_BYTES) % PAGE_BYTES;
  endfunction

  function automatic int unsigned unread_records();
    int unsigned w, r;
    w = 32'(wr_ptr);
    r = 32'(rd_ptr);
    if (w > r) return w - r;
    if (r > w) return w + (SLOT_COUNT - r) - FIRST_SLOT;
    return 0;
  endfunction

  // Apply one op to the pointer copy and return the result it should produce
  function automatic result_t advance_ring(logic [OP_W-1:0] op, logic [SLOT_W-1:0] idx);
    result_t     res;
    int unsigned w, r, nxt_slot;
    res    = '0;
    rd_ptr = SLOT_W'(ring_slot(32'(rd_ptr)));
    wr_ptr = SLOT_W'(ring_slot(32'(wr_ptr)));
    case (op)
      OP_PUT: begin
        w          = 32'(wr_ptr);
        res.access = ACC_WRITE;
        res.page   = PAGE_W'(slot_page(w));
        res.offset = OFF_W'(slot_offset(w));
        if (slot_offset(w) == 0) begin
          res.erase = 1'b1;
          // unread records on the page about to be erased: skip reader to next page
          if (w < 32'(rd_ptr) && slot_page(32'(rd_ptr)) == slot_page(w)) begin
            nxt_slot = ((slot_page(w) + 1) * PAGE_BYTES + RECORD_BYTES - 1) / RECORD_BYTES;
            rd_ptr   = SLOT_W'(ring_slot(nxt_slot));
          end
        end
        wr_ptr = SLOT_W'(ring_slot(w + 1));
      end
      OP_GET: begin
        if (unread_records() == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          r          = 32'(rd_ptr);
          res.access = ACC_READ;
          res.page   = PAGE_W'(slot_page(r));
          res.offset = OFF_W'(slot_offset(r));
          rd_ptr     = SLOT_W'(ring_slot(r + 1));
        end
      end
      OP_CLEAR: begin
        rd_ptr = SLOT_W'(FIRST_SLOT);
        wr_ptr = SLOT_W'(FIRST_SLOT);
      end
      OP_SET_RD: rd_ptr = SLOT_W'(ring_slot(32'(idx)));
      OP_SET_WR: wr_ptr = SLOT_W'(ring_slot(32'(idx)));
      default: ;
    endcase
    res.rd_slot = rd_ptr;
    res.wr_slot = wr_ptr;
    res.unread  = SLOT_W'(unread_records());
    return res;
  endfunction

  // Input driver: transfer on valid & !stall, then maybe present the next op
  always @(posedge clk_i) begin
    item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(advance_ring(op_i, new_index_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = op_queue.pop_front();
          op_i        <= nxt.op;
          new_index_i <= nxt.new_index;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // Result monitor: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result rd=%0d wr=%0d", $realtime,
                   read_slot_now_o, write_slot_now_o);
      end else begin
        exp_res = expected_results.pop_front();
        if (exp_res.status !== status_o || exp_res.erase !== erase_page_now_o ||
            exp_res.access !== flash_access_o || exp_res.page !== flash_page_o ||
            exp_res.offset !== page_offset_o || exp_res.rd_slot !== read_slot_now_o ||
            exp_res.wr_slot !== write_slot_now_o || exp_res.unread !== unread_count_o) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch exp st=%0d er=%0d acc=%0d pg=%0d off=%0d rd=%0d wr=%0d un=%0d",
                     $realtime, exp_res.status, exp_res.erase, exp_res.access, exp_res.page,
                     exp_res.offset, exp_res.rd_slot, exp_res.wr_slot, exp_res.unread);
            $display("%0t:          got st=%0d er=%0d acc=%0d pg=%0d off=%0d rd=%0d wr=%0d un=%0d",
                     $realtime, status_o, erase_page_now_o, flash_access_o, flash_page_o,
                     page_offset_o, read_slot_now_o, write_slot_now_o, unread_count_o);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_flash_ring_log_index_manager_top: errors");
        $finish;
      end
    end
  end

  task automatic queue_op(input logic [OP_W-1:0] op, input int unsigned idx, inout int n);
    item_t it;
    it.op        = op;
    it.new_index = SLOT_W'(idx);
    op_queue.push_back(it);
    n++;
  endtask

  // One random op, or now and then a page-jump sequence with random content
  task automatic queue_random(inout int n);
    int          pick, base, k;
    int unsigned idx;
    pick = $urandom_range(99);
    idx  = $urandom_range((1 << SLOT_W) - 1, 0);
    if (pick < 4) begin
      // writer on a page start, reader ahead on the same page
      base = $urandom_range(SLOT_COUNT / SLOTS_PER_PAGE - 1, 0) * SLOTS_PER_PAGE;
      queue_op(OP_SET_WR, base, n);
      queue_op(OP_SET_RD, base + $urandom_range(SLOTS_PER_PAGE - 1, 1), n);
      for (k = $urandom_range(3, 1); k > 0; k--) queue_op(OP_PUT, idx ^ k, n);
      for (k = $urandom_range(2, 0); k > 0; k--) queue_op(OP_GET, idx + k, n);
    end else if (pick < 48) begin
      queue_op(OP_PUT, idx, n);
    end else if (pick < 86) begin
      queue_op(OP_GET, idx, n);
    end else if (pick < 88) begin
      queue_op(OP_CLEAR, idx, n);
    end else if (pick < 93) begin
      queue_op(OP_SET_RD, idx, n);
    end else if (pick < 98) begin
      queue_op(OP_SET_WR, idx, n);
    end else begin
      queue_op(OP_W'($urandom_range((1 << OP_W) - 1, OP_SET_WR + 1)), idx, n);
    end
  endtask

  int send_idle_by_phase[4] = '{0, 59, 0, 16};
  int stall_by_phase[4]     = '{0, 0, 59, 16};

  initial begin
    int n, ph, u;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      n = 0;
      if (ph == 0) begin
        // get on an empty ring, then undefined ops
        queue_op(OP_GET, (1 << SLOT_W) - 1, n);
        for (u = OP_SET_WR + 1; u < (1 << OP_W); u++) queue_op(OP_W'(u), 0, n);
        // first put erases page 0
        queue_op(OP_PUT, 0, n);
        queue_op(OP_GET, 0, n);
        queue_op(OP_GET, 0, n);
        // last slot, writer and reader wrap to the first slot
        queue_op(OP_SET_WR, SLOT_COUNT - 1, n);
        queue_op(OP_SET_RD, SLOT_COUNT - 1, n);
        queue_op(OP_PUT, 0, n);
        queue_op(OP_GET, 0, n);
        // ring overflow: writer runs onto the reader
        queue_op(OP_SET_WR, 15, n);
        queue_op(OP_SET_RD, 16, n);
        queue_op(OP_PUT, 0, n);
        queue_op(OP_GET, 0, n);
        // jump past the end of the ring
        queue_op(OP_SET_RD, SLOT_COUNT - 6, n);
        queue_op(OP_SET_WR, SLOT_COUNT - SLOTS_PER_PAGE, n);
        queue_op(OP_PUT, 0, n);
        queue_op(OP_GET, 0, n);
        // ordinary jump to the next page
        queue_op(OP_SET_WR, SLOTS_PER_PAGE, n);
        queue_op(OP_SET_RD, SLOTS_PER_PAGE + 4, n);
        queue_op(OP_PUT, 0, n);
        queue_op(OP_GET, 0, n);
        // alternating index bits, then clear
        queue_op(OP_SET_RD, 'hAAA, n);
        queue_op(OP_SET_WR, 'h555, n);
        queue_op(OP_CLEAR, 'hFFF, n);
        queue_op(OP_GET, 0, n);
      end
      while (n < ITEMS_PER_PHASE) queue_random(n);

      // hold off new ops until every result is back
      while (op_queue.size() > 0 || in_valid_i || expected_results.size() > 0)
        @(negedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_flash_ring_log_index_manager_top: clean");
    end else begin
      $display("tb_flash_ring_log_index_manager_top: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/frlim_pkg.sv
rtl/frlim_in_stage.sv
rtl/frlim_core.sv
rtl/frlim_out_stage.sv
rtl/flash_ring_log_index_manager_top.sv
verif/tb_flash_ring_log_index_manager_top.sv
